// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, suspended while reset is asserted.
`define JSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define JSI_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/jsi_pkg.sv =====
// Types, character codes and control structs for the JSON stream indenter.
package jsi_pkg;

  localparam int MaxDepthDefault = 31;

  localparam logic [7:0] ChOBrace = 8'h7B;
  localparam logic [7:0] ChOBrack = 8'h5B;
  localparam logic [7:0] ChCBrace = 8'h7D;
  localparam logic [7:0] ChCBrack = 8'h5D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Phase of the output run: head byte, break byte, indent spaces, tail byte.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_BREAK,
    ST_INDENT,
    ST_TAIL
  } jsi_state_e;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       last;
    jsi_state_e sel;
  } jsi_cmd_t;

  typedef struct packed {
    logic has_break;
    logic has_tail;
    logic indent_nz;
    logic indent_one;
    logic out_full;
  } jsi_status_t;

endpackage

// ===== sv/json_stream_indenter.sv =====
// An accepted input is loaded into the run descriptor; the sequencer then moves its
// head byte into the output register. An item produces N bytes (N from 1 to 64 at
// the default MAX_DEPTH), one byte per cycle from the output register fed by the
// run sequencer while the output does not stall. Output stalls hold the sequencer;
// the next input is taken once the run's last byte sits in the output register.
// Reset clears depth, string and escape flags and the output valid.
module json_stream_indenter #(
  parameter int MAX_DEPTH = jsi_pkg::MaxDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jsi_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsi_pkg::out_item_t out_item_o
);

  jsi_pkg::jsi_cmd_t    cmd;
  jsi_pkg::jsi_status_t status;

  jsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  jsi_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sv/jsi_ctrl.sv =====
// Run sequencer: steps through head, break, indent and tail of each output run.
module jsi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 out_stall_i,
  input  jsi_pkg::jsi_status_t status_i,
  output jsi_pkg::jsi_cmd_t    cmd_o
);

  jsi_pkg::jsi_state_e state_q, state_d;
  jsi_pkg::jsi_state_e after_break, after_head;
  logic                adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    adv         = !status_i.out_full || !out_stall_i;
    after_break = status_i.indent_nz ? jsi_pkg::ST_INDENT :
                  (status_i.has_tail ? jsi_pkg::ST_TAIL : jsi_pkg::ST_IDLE);
    after_head  = status_i.has_break ? jsi_pkg::ST_BREAK : after_break;
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cmd_o       = '{load: 1'b0, emit: 1'b0, last: 1'b0, sel: state_q};
    unique case (state_q)
      jsi_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = jsi_pkg::ST_HEAD;
        end
      end
      jsi_pkg::ST_HEAD: begin
        if (adv) state_d = after_head;
      end
      jsi_pkg::ST_BREAK: begin
        if (adv) state_d = after_break;
      end
      jsi_pkg::ST_INDENT: begin
        if (adv && status_i.indent_one) begin
          state_d = status_i.has_tail ? jsi_pkg::ST_TAIL : jsi_pkg::ST_IDLE;
        end
      end
      jsi_pkg::ST_TAIL: begin
        if (adv) state_d = jsi_pkg::ST_IDLE;
      end
      default: state_d = jsi_pkg::ST_IDLE;
    endcase
    if (state_q != jsi_pkg::ST_IDLE && adv) begin
      cmd_o.emit = 1'b1;
      cmd_o.last = (state_d == jsi_pkg::ST_IDLE);
    end
  end

endmodule

// ===== sv/jsi_datapath.sv =====
// Decode, nesting state, run descriptor and output register.
module jsi_datapath #(
  parameter int MAX_DEPTH = jsi_pkg::MaxDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jsi_pkg::in_item_t    in_item_i,
  input  jsi_pkg::jsi_cmd_t    cmd_i,
  input  logic                 out_stall_i,
  output jsi_pkg::jsi_status_t status_o,
  output logic                 out_valid_o,
  output jsi_pkg::out_item_t   out_item_o
);

  localparam int DepthW  = $clog2(MAX_DEPTH + 1);
  localparam int IndentW = DepthW + 1;

  logic [DepthW-1:0]  depth_q, depth_d;
  logic               in_str_q, in_str_d;
  logic               esc_q, esc_d;

  logic [7:0]         head_q, head_d;
  logic [7:0]         brk_q, brk_d;
  logic [7:0]         tail_q;
  logic               has_brk_q, has_brk_d;
  logic               has_tail_q, has_tail_d;
  logic [IndentW-1:0] indent_q, indent_d;

  logic               out_valid_q;
  jsi_pkg::out_item_t out_q;

  logic [7:0]         c;
  logic [DepthW-1:0]  up_depth, down_depth;
  logic [7:0]         emit_byte;

  assign c          = in_item_i.text_byte;
  assign up_depth   = (depth_q < DepthW'(MAX_DEPTH)) ? depth_q + DepthW'(1) : depth_q;
  assign down_depth = (depth_q != '0) ? depth_q - DepthW'(1) : depth_q;

  always_comb begin
    depth_d    = depth_q;
    in_str_d   = in_str_q;
    esc_d      = esc_q;
    head_d     = c;
    brk_d      = jsi_pkg::ChNl;
    has_brk_d  = 1'b0;
    has_tail_d = 1'b0;
    indent_d   = '0;
    if (in_item_i.line_end) begin
      head_d   = jsi_pkg::ChNl;
      depth_d  = '0;
      in_str_d = 1'b0;
      esc_d    = 1'b0;
    end else if (in_str_q) begin
      if (esc_q) begin
        esc_d = 1'b0;
      end else if (c == jsi_pkg::ChBslash) begin
        esc_d = 1'b1;
      end else if (c == jsi_pkg::ChQuote) begin
        in_str_d = 1'b0;
      end
    end else begin
      unique case (c) inside
        jsi_pkg::ChQuote: in_str_d = 1'b1;
        jsi_pkg::ChOBrace, jsi_pkg::ChOBrack: begin
          depth_d   = up_depth;
          has_brk_d = 1'b1;
          indent_d  = {up_depth, 1'b0};
        end
        jsi_pkg::ChCBrace, jsi_pkg::ChCBrack: begin
          // newline first, bracket last
          depth_d    = down_depth;
          head_d     = jsi_pkg::ChNl;
          has_tail_d = 1'b1;
          indent_d   = {down_depth, 1'b0};
        end
        jsi_pkg::ChComma: begin
          has_brk_d = 1'b1;
          indent_d  = {depth_q, 1'b0};
        end
        jsi_pkg::ChColon: begin
          has_brk_d = 1'b1;
          brk_d     = jsi_pkg::ChSpace;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      in_str_q    <= 1'b0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        depth_q  <= depth_d;
        in_str_q <= in_str_d;
        esc_q    <= esc_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      head_q     <= head_d;
      brk_q      <= brk_d;
      tail_q     <= c;
      has_brk_q  <= has_brk_d;
      has_tail_q <= has_tail_d;
      indent_q   <= indent_d;
    end else if (cmd_i.emit && cmd_i.sel == jsi_pkg::ST_INDENT) begin
      indent_q <= indent_q - IndentW'(1);
    end
    if (cmd_i.emit) begin
      out_q <= '{out_byte: emit_byte, run_last: cmd_i.last};
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      jsi_pkg::ST_BREAK:  emit_byte = brk_q;
      jsi_pkg::ST_INDENT: emit_byte = jsi_pkg::ChSpace;
      jsi_pkg::ST_TAIL:   emit_byte = tail_q;
      default:            emit_byte = head_q;
    endcase
  end

  assign status_o = '{has_break:  has_brk_q,
                      has_tail:   has_tail_q,
                      indent_nz:  indent_q != '0,
                      indent_one: indent_q == IndentW'(1),
                      out_full:   out_valid_q};
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== sv/jsi_checker.sv =====
// Port-level assertions for the JSON stream indenter, bound to the top level.
`include "assert_macros.svh"

module jsi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input jsi_pkg::out_item_t out_item_o
);

  `JSI_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "out valid dropped under stall")
  `JSI_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_item_o), "out payload changed under stall")
  `JSI_ASSERT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "input taken while a run is pending")
  `JSI_ASSERT(a_free_on_last, clk_i, rst_ni, $fell(in_stall_o) |-> out_valid_o && out_item_o.run_last, "input freed before last byte")
  `JSI_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o, "out valid during reset")

endmodule

bind json_stream_indenter jsi_checker u_jsi_checker (.*);
